/* rtl/als_pkg.sv */
// package for the ascending list sorter
// widths, default capacity and the link record passed between neighboring cells
// no dependencies

package als_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	// what one cell shows to its neighbors
	typedef struct packed {
		logic                     take;
		logic                     occ;
		logic signed [DATA_W-1:0] value;
	} link_t;

endpackage

/* rtl/als_cell.sv */
// one cell of the insertion chain: holds one value and an occupied bit
// depends on als_pkg

module als_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ins,
	input  logic signed [als_pkg::DATA_W-1:0] x,
	input  logic                             shift,
	input  als_pkg::link_t                   left,
	input  als_pkg::link_t                   right,
	output als_pkg::link_t                   link
);
	import als_pkg::*;

	logic                     occ_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     take;

	// chain is kept ascending and empty cells sit at the end, so take is monotone
	assign take = ins && (!occ_q || (x < value_q));

	assign link.take  = take;
	assign link.occ   = occ_q;
	assign link.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift) begin
			occ_q <= right.occ;
		end else if (ins) begin
			if (left.take) begin
				occ_q <= left.occ;
			end else if (take) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= right.value;
		end else if (ins) begin
			if (left.take) begin
				value_q <= left.value;
			end else if (take) begin
				value_q <= x;
			end
		end
	end

endmodule

/* rtl/ascending_list_sorter_top.sv */
// Sorts a sequence of signed 32-bit values into ascending order, duplicates
// kept. While collecting, the block takes one item per cycle; each item is
// compared against every held value at once and inserted in place, so the
// row of cells is always sorted. The item flagged tlast ends the sequence;
// from the next cycle the cells shift toward cell 0 and one result leaves per
// cycle while the sink is ready, the largest flagged tlast. A sequence goes
// in through the single insert port and out through the single shift-out end
// of the chain. No input is taken while results are going out. Up to CAPACITY
// values are held; later items of the same sequence are dropped and every
// result of that sequence then carries tuser high.
// depends on als_pkg and als_cell

module ascending_list_sorter_top #(
	parameter int CAPACITY = als_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [als_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [als_pkg::DATA_W-1:0] m_tdata,  // [31:0] value_res
	output logic                              m_tlast,
	output logic                              m_tuser   // [0] overflow
);
	import als_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_DRAIN   = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic accept;
	logic store;
	logic shift;

	link_t links [CAPACITY];
	link_t edge_l;
	link_t edge_r;

	assign s_tready = (state_q == ST_COLLECT);
	assign accept   = s_tvalid && s_tready;
	assign store    = accept && (count_q < CNT_W'(CAPACITY));

	assign m_tvalid = (state_q == ST_DRAIN);
	assign shift    = m_tvalid && m_tready;
	assign m_tdata  = links[0].value;
	assign m_tlast  = !links[1].occ;
	assign m_tuser  = ovf_q;

	assign edge_l = '{take: 1'b0, occ: 1'b0, value: '0};
	assign edge_r = '{take: 1'b0, occ: 1'b0, value: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		als_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ins   (store),
			.x     (s_tdata),
			.shift (shift),
			.left  ((i == 0) ? edge_l : links[(i == 0) ? 0 : i - 1]),
			.right ((i == CAPACITY - 1) ? edge_r : links[(i == CAPACITY - 1) ? i : i + 1]),
			.link  (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (store) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (shift && m_tlast) begin
						state_q <= ST_COLLECT;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

/* rtl/als_chk.sv */
// port-level checks for the ascending list sorter, bound to the top level
// depends on als_pkg and ascending_list_sorter_top

module als_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic signed [als_pkg::DATA_W-1:0] s_tdata,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic signed [als_pkg::DATA_W-1:0] m_tdata,
	input logic                              m_tlast,
	input logic                              m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// input is closed while results go out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open during drain");

	// results come out ascending with one overflow flag per sequence
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata >= $past(m_tdata)) && (m_tuser == $past(m_tuser)))
		else $error("results not ascending");

	// after the last result the block collects again
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("drain did not end after last item");

endmodule

bind ascending_list_sorter_top als_chk u_als_chk (.*);
